// ----- sv/assert_macros.svh -----
// Assertion macros shared by the servo slew channel RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define SSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/ssc_pkg.sv -----
// Shared types, codes and constants of the servo slew channel controller.
`default_nettype none
package ssc_pkg;

   localparam int SPEED_PIVOT_DEFAULT  = 128;
   localparam int CUTOFF_POLLS_DEFAULT = 10;
   localparam int QUEUE_DEPTH          = 4;

   // Pulse width mapping, quarter-microsecond ticks.
   localparam logic [13:0] TICK_STD_BASE  = 14'd3600;
   localparam logic [13:0] TICK_STD_SLOPE = 14'd19;
   localparam logic [13:0] TICK_EXT_BASE  = 14'd1400;
   localparam logic [13:0] TICK_EXT_SLOPE = 14'd36;

   typedef enum logic [1:0] {
      FUNC_POLL    = 2'd0,
      FUNC_ON      = 2'd1,
      FUNC_OFF     = 2'd2,
      FUNC_SET_POS = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_AT_START = 2'd1,
      EV_AT_END   = 2'd2,
      EV_MIDWAY   = 2'd3
   } event_kind_type;

   typedef enum logic [2:0] {
      CSR_START_POSITION     = 3'd0,
      CSR_END_POSITION       = 3'd1,
      CSR_SPEED_TOWARD_END   = 3'd2,
      CSR_SPEED_TOWARD_START = 3'd3,
      CSR_TRIGGER_INVERTED   = 3'd4,
      CSR_EVENT_INVERTED     = 3'd5,
      CSR_CUTOFF_ENABLE      = 3'd6,
      CSR_EXTENDED_TRAVEL    = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_OFF      = 4'b0001,
      ST_STARTING = 4'b0010,
      ST_MOVING   = 4'b0100,
      ST_STOPPED  = 4'b1000
   } motion_type;

   // Event slots in delivery order.
   localparam logic [1:0] SLOT_DEPART  = 2'd0;
   localparam logic [1:0] SLOT_MIDWAY  = 2'd1;
   localparam logic [1:0] SLOT_ARRIVAL = 2'd2;

   // One classified step, handed from front to back.
   typedef struct packed {
      logic [2:0]      ev_valid;
      logic [2:0][1:0] ev_kind;
      logic [2:0]      ev_on;
      logic [7:0]      position;
      logic            pulse_enabled;
   } step_rec_type;

endpackage
`default_nettype wire

// ----- sv/ssc_front.sv -----
// Front end: configuration registers, channel state and per-item step classification.
`default_nettype none
module ssc_front #(
   parameter int SPEED_PIVOT  = ssc_pkg::SPEED_PIVOT_DEFAULT,
   parameter int CUTOFF_POLLS = ssc_pkg::CUTOFF_POLLS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept_i,
   input  wire logic [1:0]           func_i,
   input  wire logic [7:0]           new_position_i,
   input  wire logic                 csr_write_enable,
   input  wire logic [2:0]           csr_index,
   input  wire logic [7:0]           csr_write_data,
   output ssc_pkg::step_rec_type     rec_o,
   output logic                      extended_travel_o
);

   localparam logic [7:0] PIVOT  = 8'(SPEED_PIVOT);
   localparam logic [3:0] CUTOFF = 4'(CUTOFF_POLLS);

   // Configuration registers
   logic [7:0] start_pos_ff, end_pos_ff, speed_end_ff, speed_start_ff;
   logic       trig_inv_ff, ev_inv_ff, cutoff_en_ff, ext_travel_ff;

   // Channel state
   ssc_pkg::motion_type state_ff, state_in;
   logic [7:0] cur_ff, cur_in, tgt_ff, tgt_in;
   logic [7:0] spp_ff, spp_in, pps_ff, pps_in, cd_ff, cd_in;
   logic [3:0] stopped_ff, stopped_in;

   logic [7:0] mid;
   logic [8:0] sum_w;
   logic [7:0] step_w;
   logic [7:0] code_w;
   ssc_pkg::step_rec_type rec_w;

   assign mid = 8'({1'b0, end_pos_ff[7:1]} + {1'b0, start_pos_ff[7:1]});

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         start_pos_ff   <= 8'd0;
         end_pos_ff     <= 8'd255;
         speed_end_ff   <= 8'd0;
         speed_start_ff <= 8'd0;
         trig_inv_ff    <= 1'b0;
         ev_inv_ff      <= 1'b0;
         cutoff_en_ff   <= 1'b0;
         ext_travel_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         case (ssc_pkg::csr_index_type'(csr_index))
            ssc_pkg::CSR_START_POSITION:     start_pos_ff   <= csr_write_data;
            ssc_pkg::CSR_END_POSITION:       end_pos_ff     <= csr_write_data;
            ssc_pkg::CSR_SPEED_TOWARD_END:   speed_end_ff   <= csr_write_data;
            ssc_pkg::CSR_SPEED_TOWARD_START: speed_start_ff <= csr_write_data;
            ssc_pkg::CSR_TRIGGER_INVERTED:   trig_inv_ff    <= csr_write_data[0];
            ssc_pkg::CSR_EVENT_INVERTED:     ev_inv_ff      <= csr_write_data[0];
            ssc_pkg::CSR_CUTOFF_ENABLE:      cutoff_en_ff   <= csr_write_data[0];
            ssc_pkg::CSR_EXTENDED_TRAVEL:    ext_travel_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Classify the item and work out the next state
   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      tgt_in     = tgt_ff;
      spp_in     = spp_ff;
      pps_in     = pps_ff;
      cd_in      = cd_ff;
      stopped_in = stopped_ff;
      sum_w      = 9'd0;
      step_w     = cur_ff;
      code_w     = speed_end_ff;
      rec_w      = '0;

      case (ssc_pkg::func_type'(func_i))
         ssc_pkg::FUNC_POLL: begin
            if (state_ff == ssc_pkg::ST_STARTING) begin
               rec_w.ev_valid[ssc_pkg::SLOT_DEPART] = 1'b1;
               rec_w.ev_kind[ssc_pkg::SLOT_DEPART]  = (cur_ff == start_pos_ff) ?
                  ssc_pkg::EV_AT_START : ssc_pkg::EV_AT_END;
               rec_w.ev_on[ssc_pkg::SLOT_DEPART]    = ev_inv_ff;
            end
            if (state_ff == ssc_pkg::ST_STARTING || state_ff == ssc_pkg::ST_MOVING) begin
               if (tgt_ff > cur_ff) begin
                  // move up, saturate, clamp at target
                  if (spp_ff != 8'd0) begin
                     sum_w  = {1'b0, cur_ff} + {1'b0, spp_ff};
                     step_w = sum_w[8] ? 8'hFF : sum_w[7:0];
                  end else begin
                     cd_in = cd_ff - 8'd1;
                     if (cd_in == 8'd0) begin
                        step_w = cur_ff + 8'd1;
                        cd_in  = pps_ff;
                     end
                  end
                  cur_in = (step_w > tgt_ff) ? tgt_ff : step_w;
                  if (cur_ff < mid && cur_in >= mid) begin
                     rec_w.ev_valid[ssc_pkg::SLOT_MIDWAY] = 1'b1;
                     rec_w.ev_kind[ssc_pkg::SLOT_MIDWAY]  = ssc_pkg::EV_MIDWAY;
                     rec_w.ev_on[ssc_pkg::SLOT_MIDWAY]    = ~ev_inv_ff;
                  end
               end else if (tgt_ff < cur_ff) begin
                  // move down, saturate, clamp at target
                  if (spp_ff != 8'd0) begin
                     step_w = (cur_ff < spp_ff) ? 8'd0 : cur_ff - spp_ff;
                  end else begin
                     cd_in = cd_ff - 8'd1;
                     if (cd_in == 8'd0) begin
                        step_w = cur_ff - 8'd1;
                        cd_in  = pps_ff;
                     end
                  end
                  cur_in = (step_w < tgt_ff) ? tgt_ff : step_w;
                  if (cur_ff > mid && cur_in <= mid) begin
                     rec_w.ev_valid[ssc_pkg::SLOT_MIDWAY] = 1'b1;
                     rec_w.ev_kind[ssc_pkg::SLOT_MIDWAY]  = ssc_pkg::EV_MIDWAY;
                     rec_w.ev_on[ssc_pkg::SLOT_MIDWAY]    = ev_inv_ff;
                  end
               end
               if (cur_in == tgt_ff) begin
                  state_in   = ssc_pkg::ST_STOPPED;
                  stopped_in = 4'd0;
                  rec_w.ev_valid[ssc_pkg::SLOT_ARRIVAL] = 1'b1;
                  rec_w.ev_kind[ssc_pkg::SLOT_ARRIVAL]  = (cur_in == start_pos_ff) ?
                     ssc_pkg::EV_AT_START : ssc_pkg::EV_AT_END;
                  rec_w.ev_on[ssc_pkg::SLOT_ARRIVAL]    = ~ev_inv_ff;
               end else begin
                  state_in = ssc_pkg::ST_MOVING;
               end
            end else if (state_ff == ssc_pkg::ST_STOPPED) begin
               if (stopped_ff != 4'hF) begin
                  stopped_in = stopped_ff + 4'd1;
               end
            end
            // cut the pulses once stopped long enough, if cutoff is enabled
            if (state_in == ssc_pkg::ST_STOPPED && cutoff_en_ff && stopped_in > CUTOFF) begin
               state_in = ssc_pkg::ST_OFF;
            end
         end
         ssc_pkg::FUNC_ON, ssc_pkg::FUNC_OFF: begin
            if (ssc_pkg::func_type'(func_i) == ssc_pkg::FUNC_ON) begin
               tgt_in = trig_inv_ff ? start_pos_ff : end_pos_ff;
               code_w = speed_end_ff;
            end else begin
               tgt_in = trig_inv_ff ? end_pos_ff : start_pos_ff;
               code_w = speed_start_ff;
            end
            if (code_w > PIVOT) begin
               spp_in = code_w - PIVOT;
               pps_in = 8'd0;
            end else begin
               pps_in = PIVOT - code_w + 8'd1;
               cd_in  = 8'd1;
               spp_in = 8'd0;
            end
            state_in = ssc_pkg::ST_STARTING;
         end
         default: begin
            tgt_in = new_position_i;
            cur_in = new_position_i;
         end
      endcase

      rec_w.position      = cur_in;
      rec_w.pulse_enabled = (state_in != ssc_pkg::ST_OFF);
   end

   // Advance channel state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ssc_pkg::ST_OFF;
         cur_ff     <= 8'd0;
         tgt_ff     <= 8'd0;
         spp_ff     <= 8'd0;
         pps_ff     <= 8'd0;
         cd_ff      <= 8'd0;
         stopped_ff <= 4'd0;
      end else if (accept_i) begin
         state_ff   <= state_in;
         cur_ff     <= cur_in;
         tgt_ff     <= tgt_in;
         spp_ff     <= spp_in;
         pps_ff     <= pps_in;
         cd_ff      <= cd_in;
         stopped_ff <= stopped_in;
      end
   end

   assign rec_o             = rec_w;
   assign extended_travel_o = ext_travel_ff;

endmodule
`default_nettype wire

// ----- sv/ssc_queue.sv -----
// Short queue of classified steps between front and back.
`default_nettype none
`include "assert_macros.svh"
module ssc_queue #(
   parameter int DEPTH = ssc_pkg::QUEUE_DEPTH
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push_i,
   input  wire ssc_pkg::step_rec_type push_rec_i,
   output logic                 full_o,
   input  wire logic            pop_i,
   output ssc_pkg::step_rec_type head_rec_o,
   output logic                 empty_o
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

   ssc_pkg::step_rec_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   // Store on push
   always_ff @(posedge clock) begin
      if (push_i) begin
         entry_ff[wr_ptr_ff] <= push_rec_i;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_i) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_P) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop_i) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_P) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push_i && !pop_i) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop_i && !push_i) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign full_o     = (count_ff == DEPTH_C);
   assign empty_o    = (count_ff == '0);
   assign head_rec_o = entry_ff[rd_ptr_ff];

   `SSC_ASSERT_ALWAYS(a_q_bound, clock, reset || (count_ff <= DEPTH_C), "queue count beyond depth")
   `SSC_ASSERT(a_q_grow, clock, reset, (push_i && !pop_i) |=> (count_ff == $past(count_ff) + 1'b1), "queue count did not grow on push")

endmodule
`default_nettype wire

// ----- sv/ssc_back.sv -----
// Back end: expands each step into its result transfers and holds the result port.
`default_nettype none
`include "assert_macros.svh"
module ssc_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_empty_i,
   input  wire ssc_pkg::step_rec_type q_head_i,
   output logic                  q_pop_o,
   input  wire logic             extended_travel_i,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic [1:0]            rsp_event_kind,
   output logic                  rsp_event_on,
   output logic                  rsp_save_request,
   output logic [7:0]            rsp_position,
   output logic [13:0]           rsp_pulse_ticks,
   output logic                  rsp_pulse_enabled,
   output logic                  rsp_last
);

   logic                  busy_ff;
   logic [2:0]            mask_ff;
   ssc_pkg::step_rec_type rec_ff;
   logic [13:0]           ticks_ff;

   logic [1:0]  sel;
   logic        any_ev;
   logic [2:0]  rest_mask;
   logic        load;
   logic [13:0] ticks_w;

   function automatic logic [13:0] TICKS(input logic [13:0] base, input logic [13:0] slope,
                                         input logic [7:0] pos);
      TICKS = 14'(base + slope * {6'd0, pos});
   endfunction

   // Pick the oldest pending event
   always_comb begin
      if (mask_ff[0]) begin
         sel = ssc_pkg::SLOT_DEPART;
      end else if (mask_ff[1]) begin
         sel = ssc_pkg::SLOT_MIDWAY;
      end else begin
         sel = ssc_pkg::SLOT_ARRIVAL;
      end
      any_ev    = |mask_ff;
      rest_mask = mask_ff & ~(3'b001 << sel);
   end

   assign rsp_empty         = !busy_ff;
   assign rsp_event_kind    = any_ev ? rec_ff.ev_kind[sel] : ssc_pkg::EV_NONE;
   assign rsp_event_on      = any_ev & rec_ff.ev_on[sel];
   assign rsp_save_request  = any_ev && (sel == ssc_pkg::SLOT_ARRIVAL);
   assign rsp_last          = (rest_mask == 3'b000);
   assign rsp_position      = rec_ff.position;
   assign rsp_pulse_enabled = rec_ff.pulse_enabled;
   assign rsp_pulse_ticks   = ticks_ff;

   // Take the next step when the port is free or its final transfer goes
   assign load    = !q_empty_i && (!busy_ff || (rsp_pop && rsp_last));
   assign q_pop_o = load;

   assign ticks_w = extended_travel_i ?
      TICKS(ssc_pkg::TICK_EXT_BASE, ssc_pkg::TICK_EXT_SLOPE, q_head_i.position) :
      TICKS(ssc_pkg::TICK_STD_BASE, ssc_pkg::TICK_STD_SLOPE, q_head_i.position);

   // Hold the payload of the step being delivered
   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff   <= q_head_i;
         ticks_ff <= ticks_w;
      end
   end

   // Drop delivered events and track occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         mask_ff <= 3'b000;
      end else if (load) begin
         busy_ff <= 1'b1;
         mask_ff <= q_head_i.ev_valid;
      end else if (busy_ff && rsp_pop) begin
         if (rsp_last) begin
            busy_ff <= 1'b0;
         end
         mask_ff <= rest_mask;
      end
   end

   `SSC_ASSERT(a_bk_hold, clock, reset, (busy_ff && rsp_pop && !rsp_last) |=> busy_ff, "result dropped before its final transfer")
   `SSC_ASSERT(a_bk_drain, clock, reset, (busy_ff && rsp_pop && !rsp_last) |=> ($countones(mask_ff) == $past($countones(mask_ff)) - 1), "event mask did not shrink by one")

endmodule
`default_nettype wire

// ----- sv/servo_slew_channel_controller_top.sv -----
// Top level of the servo slew channel controller: front, step queue and back.
//
//  channel | ports                          | transfer when
//  --------+--------------------------------+---------------------------
//  request | req_push/req_full, req_func,   | req_push && !req_full
//          | req_new_position               |
//  result  | rsp_empty/rsp_pop, rsp_* data  | rsp_pop && !rsp_empty
//  csr     | csr_write_enable, csr_index,   | csr_write_enable
//          | csr_write_data                 |
//
// One request is taken per cycle while the step queue has room.
// Each request yields 1 to 3 results, one per cycle while rsp_pop is held, so the
// sustained request rate is bounded by the results per request, set by the back end's
// single result register. A request's step is registered in the step queue and then
// in the back end's result register before its first result shows. Synchronous reset
// clears channel state, queue and result port and loads the register reset values;
// no clearing pass follows. A stalled result side fills the queue, then raises req_full.
`default_nettype none
module servo_slew_channel_controller_top #(
   parameter int SPEED_PIVOT  = ssc_pkg::SPEED_PIVOT_DEFAULT,
   parameter int CUTOFF_POLLS = ssc_pkg::CUTOFF_POLLS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_new_position,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [1:0]       rsp_event_kind,
   output logic             rsp_event_on,
   output logic             rsp_save_request,
   output logic [7:0]       rsp_position,
   output logic [13:0]      rsp_pulse_ticks,
   output logic             rsp_pulse_enabled,
   output logic             rsp_last,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_write_data
);

   logic                  accept;
   ssc_pkg::step_rec_type front_rec;
   ssc_pkg::step_rec_type head_rec;
   logic                  q_empty;
   logic                  q_pop;
   logic                  ext_travel;

   assign accept = req_push && !req_full;

   ssc_front #(
      .SPEED_PIVOT  (SPEED_PIVOT),
      .CUTOFF_POLLS (CUTOFF_POLLS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .accept_i          (accept),
      .func_i            (req_func),
      .new_position_i    (req_new_position),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rec_o             (front_rec),
      .extended_travel_o (ext_travel)
   );

   ssc_queue #(
      .DEPTH (ssc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_i     (accept),
      .push_rec_i (front_rec),
      .full_o     (req_full),
      .pop_i      (q_pop),
      .head_rec_o (head_rec),
      .empty_o    (q_empty)
   );

   ssc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty_i         (q_empty),
      .q_head_i          (head_rec),
      .q_pop_o           (q_pop),
      .extended_travel_i (ext_travel),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_event_on      (rsp_event_on),
      .rsp_save_request  (rsp_save_request),
      .rsp_position      (rsp_position),
      .rsp_pulse_ticks   (rsp_pulse_ticks),
      .rsp_pulse_enabled (rsp_pulse_enabled),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire
